// ----- src/tar_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tar_pkg: shared types, constants and functions of the action repeater
// Holds the action count, field widths, register map and the priority
// encoder used by the classifier.
// ----------------------------------------------------------------------------
package tar_pkg;

    localparam int NUM_ACTIONS = 8;
    localparam int MASK_BITS   = 8;
    localparam int USED_BITS   = (NUM_ACTIONS < MASK_BITS) ? NUM_ACTIONS : MASK_BITS;
    localparam int ACT_W       = 4;
    localparam int DT_W        = 16;
    localparam int DELAY_W     = 24;
    localparam int HOLD_W      = 25;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [DELAY_W-1:0] INITIAL_DELAY_RESET = 24'd300000;
    localparam logic [DELAY_W-1:0] REPEAT_DELAY_RESET  = 24'd100000;
    localparam logic [HOLD_W-1:0]  HOLD_MAX            = {HOLD_W{1'b1}};

    // Register index, taken from paddr[2]
    localparam logic REG_INITIAL_DELAY = 1'b0;
    localparam logic REG_REPEAT_DELAY  = 1'b1;

    localparam logic [ACT_W-1:0] ACT_NONE = '0;

    // One classified tick, as passed from the front end to the back end.
    typedef struct packed {
        logic [ACT_W-1:0]     press_act;
        logic [MASK_BITS-1:0] held_mask;
        logic [ACT_W-1:0]     first_held;
        logic [DT_W-1:0]      elapsed;
    } class_t;

    // Lowest set bit, numbered from one; zero when nothing is set.
    function automatic logic [ACT_W-1:0] first_action(input logic [MASK_BITS-1:0] mask);
        logic [ACT_W-1:0] res;
        res = ACT_NONE;
        for (int i = USED_BITS - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                res = ACT_W'(i + 1);
            end
        end
        return res;
    endfunction

endpackage

// ----- src/tar_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tar_regs: configuration register file
// Holds the initial and repeat delays behind a simple APB-style port.
// ----------------------------------------------------------------------------
module tar_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tar_pkg::ADDR_W-1:0]      paddr,
    input  logic [tar_pkg::DATA_W-1:0]      pwdata,
    output logic [tar_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    output logic [tar_pkg::DELAY_W-1:0]     initial_delay,
    output logic [tar_pkg::DELAY_W-1:0]     repeat_delay
);

    logic [tar_pkg::DELAY_W-1:0] initial_delay_reg;
    logic [tar_pkg::DELAY_W-1:0] repeat_delay_reg;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_delay_reg <= tar_pkg::INITIAL_DELAY_RESET;
            repeat_delay_reg  <= tar_pkg::REPEAT_DELAY_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == tar_pkg::REG_INITIAL_DELAY)
            begin
                initial_delay_reg <= pwdata[tar_pkg::DELAY_W-1:0];
            end
            else
            begin
                repeat_delay_reg <= pwdata[tar_pkg::DELAY_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == tar_pkg::REG_INITIAL_DELAY)
        begin
            prdata = tar_pkg::DATA_W'(initial_delay_reg);
        end
        else
        begin
            prdata = tar_pkg::DATA_W'(repeat_delay_reg);
        end
    end

    assign initial_delay = initial_delay_reg;
    assign repeat_delay  = repeat_delay_reg;

endmodule

// ----- src/tar_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tar_front: tick classifier
// Picks the fresh press by source priority and folds the held masks into
// one mask plus the lowest held action of the first source that holds one.
// ----------------------------------------------------------------------------
module tar_front
(
    input  logic [tar_pkg::MASK_BITS-1:0] key_pressed_mask,
    input  logic [tar_pkg::MASK_BITS-1:0] key_held_mask,
    input  logic [tar_pkg::MASK_BITS-1:0] mouse_pressed_mask,
    input  logic [tar_pkg::MASK_BITS-1:0] mouse_held_mask,
    input  logic [tar_pkg::MASK_BITS-1:0] pad_pressed_mask,
    input  logic [tar_pkg::MASK_BITS-1:0] pad_held_mask,
    input  logic [tar_pkg::DT_W-1:0]      elapsed_us,
    output tar_pkg::class_t               cls
);

    logic [tar_pkg::ACT_W-1:0] key_press;
    logic [tar_pkg::ACT_W-1:0] mouse_press;
    logic [tar_pkg::ACT_W-1:0] pad_press;
    logic [tar_pkg::ACT_W-1:0] key_held;
    logic [tar_pkg::ACT_W-1:0] mouse_held;
    logic [tar_pkg::ACT_W-1:0] pad_held;

    always_comb
    begin
        key_press   = tar_pkg::first_action(key_pressed_mask);
        mouse_press = tar_pkg::first_action(mouse_pressed_mask);
        pad_press   = tar_pkg::first_action(pad_pressed_mask);
        key_held    = tar_pkg::first_action(key_held_mask);
        mouse_held  = tar_pkg::first_action(mouse_held_mask);
        pad_held    = tar_pkg::first_action(pad_held_mask);

        if (key_press != tar_pkg::ACT_NONE)
        begin
            cls.press_act = key_press;
        end
        else if (mouse_press != tar_pkg::ACT_NONE)
        begin
            cls.press_act = mouse_press;
        end
        else
        begin
            cls.press_act = pad_press;
        end

        if (key_held != tar_pkg::ACT_NONE)
        begin
            cls.first_held = key_held;
        end
        else if (mouse_held != tar_pkg::ACT_NONE)
        begin
            cls.first_held = mouse_held;
        end
        else
        begin
            cls.first_held = pad_held;
        end

        cls.held_mask = key_held_mask | mouse_held_mask | pad_held_mask;
        cls.elapsed   = elapsed_us;
    end

endmodule

// ----- src/tar_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tar_queue: two-entry queue of classified ticks
// Decouples the classifier from the repeat engine so either may stall.
// ----------------------------------------------------------------------------
module tar_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tar_pkg::class_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output tar_pkg::class_t pop_data
);

    tar_pkg::class_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/tar_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tar_back: repeat engine
// Tracks the held action and the hold timer and registers one result per
// classified tick.
// ----------------------------------------------------------------------------
module tar_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cls_valid,
    input  tar_pkg::class_t               cls,
    output logic                          cls_take,
    input  logic [tar_pkg::DELAY_W-1:0]   initial_delay,
    input  logic [tar_pkg::DELAY_W-1:0]   repeat_delay,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tar_pkg::ACT_W-1:0]     active_action
);

    logic [tar_pkg::ACT_W-1:0]  last_held_reg;
    logic [tar_pkg::ACT_W-1:0]  last_held_next;
    logic                       repeating_reg;
    logic                       repeating_next;
    logic [tar_pkg::HOLD_W-1:0] hold_reg;
    logic [tar_pkg::HOLD_W-1:0] hold_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [tar_pkg::ACT_W-1:0]  action_reg;
    logic [tar_pkg::ACT_W-1:0]  action_next;

    logic                       keep;
    logic [tar_pkg::ACT_W-1:0]  held;
    logic [tar_pkg::ACT_W-1:0]  held_idx;
    logic [tar_pkg::HOLD_W:0]   sum;
    logic [tar_pkg::HOLD_W-1:0] sat;
    logic [tar_pkg::HOLD_W-1:0] delay;

    assign cls_take = cls_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        held_idx = last_held_reg - 1'b1;
        keep     = (last_held_reg != tar_pkg::ACT_NONE) &&
                   cls.held_mask[held_idx[2:0]];
        held     = keep ? last_held_reg : cls.first_held;

        sum = (tar_pkg::HOLD_W + 1)'(hold_reg) + (tar_pkg::HOLD_W + 1)'(cls.elapsed);
        sat = sum[tar_pkg::HOLD_W] ? tar_pkg::HOLD_MAX : sum[tar_pkg::HOLD_W-1:0];
        // The first repeat waits for the initial delay, later ones for the repeat delay
        delay = repeating_reg ? tar_pkg::HOLD_W'(repeat_delay)
                              : tar_pkg::HOLD_W'(initial_delay);

        last_held_next = last_held_reg;
        repeating_next = repeating_reg;
        hold_next      = hold_reg;
        action_next    = action_reg;

        if (cls_take)
        begin
            if (cls.press_act != tar_pkg::ACT_NONE)
            begin
                last_held_next = cls.press_act;
                repeating_next = 1'b0;
                hold_next      = '0;
                action_next    = cls.press_act;
            end
            else if (held != last_held_reg)
            begin
                last_held_next = held;
                repeating_next = 1'b0;
                hold_next      = '0;
                action_next    = held;
            end
            else if (held == tar_pkg::ACT_NONE)
            begin
                action_next = tar_pkg::ACT_NONE;
            end
            else if (sat >= delay)
            begin
                repeating_next = 1'b1;
                hold_next      = sat - delay;
                action_next    = held;
            end
            else
            begin
                hold_next   = sat;
                action_next = tar_pkg::ACT_NONE;
            end
        end

        if (cls_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_held_reg <= tar_pkg::ACT_NONE;
            repeating_reg <= 1'b0;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            last_held_reg <= last_held_next;
            repeating_reg <= repeating_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
    end

    assign out_valid     = out_valid_reg;
    assign active_action = action_reg;

endmodule

// ----- src/typematic_action_repeater.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typematic_action_repeater: auto-repeat of mapped input actions
// Turns per-tick press and held masks from three sources into a stream of
// actions with typematic delay and repeat.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Carries
//  -------   ---------------------  ---------------------------------------
//  in        in_valid / in_ready    six press/held masks and elapsed_us
//  out       out_valid / out_ready  active_action, one per input transfer
//  config    psel/penable/pready    initial and repeat delay registers
//
// One input transfer is taken every clock cycle while the queue has a free
// entry; the repeat engine updates its state once per tick, which sets that
// rate. The tick is queued at the transfer edge; the repeat engine registers
// its result as it takes the tick, which a stalled output can hold back.
// rst_n clears the queue, the hold state and the output valid flag, and
// loads the delay registers with 300000 us and 100000 us.
// When the output is stalled the two-entry queue absorbs ticks; in_ready
// falls only once both entries are occupied.
//
module typematic_action_repeater
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tar_pkg::MASK_BITS-1:0]   key_pressed_mask,
    input  logic [tar_pkg::MASK_BITS-1:0]   key_held_mask,
    input  logic [tar_pkg::MASK_BITS-1:0]   mouse_pressed_mask,
    input  logic [tar_pkg::MASK_BITS-1:0]   mouse_held_mask,
    input  logic [tar_pkg::MASK_BITS-1:0]   pad_pressed_mask,
    input  logic [tar_pkg::MASK_BITS-1:0]   pad_held_mask,
    input  logic [tar_pkg::DT_W-1:0]        elapsed_us,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tar_pkg::ACT_W-1:0]       active_action,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tar_pkg::ADDR_W-1:0]      paddr,
    input  logic [tar_pkg::DATA_W-1:0]      pwdata,
    output logic [tar_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    tar_pkg::class_t             front_cls;
    tar_pkg::class_t             queue_cls;
    logic                        queue_full;
    logic                        queue_not_empty;
    logic                        queue_pop;
    logic                        in_transfer;
    logic [tar_pkg::DELAY_W-1:0] initial_delay;
    logic [tar_pkg::DELAY_W-1:0] repeat_delay;

    // The front end accepts whenever the queue has a free entry.
    assign in_ready    = !queue_full;
    assign in_transfer = in_valid && in_ready;

    tar_regs u_regs
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .initial_delay (initial_delay),
        .repeat_delay  (repeat_delay)
    );

    // Priority encoding of presses and held masks needs no state, so it is
    // done as the tick arrives and only the condensed form is queued.
    tar_front u_front
    (
        .key_pressed_mask   (key_pressed_mask),
        .key_held_mask      (key_held_mask),
        .mouse_pressed_mask (mouse_pressed_mask),
        .mouse_held_mask    (mouse_held_mask),
        .pad_pressed_mask   (pad_pressed_mask),
        .pad_held_mask      (pad_held_mask),
        .elapsed_us         (elapsed_us),
        .cls                (front_cls)
    );

    tar_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_transfer),
        .push_data (front_cls),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .pop_data  (queue_cls)
    );

    // The back end owns all state that one tick leaves for the next.
    tar_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cls_valid     (queue_not_empty),
        .cls           (queue_cls),
        .cls_take      (queue_pop),
        .initial_delay (initial_delay),
        .repeat_delay  (repeat_delay),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .active_action (active_action)
    );

endmodule
